@@ rtl/font_palette_gradient_core_defines.svh @@
// assertion helpers for the font palette gradient core
`ifndef FONT_PALETTE_GRADIENT_CORE_DEFINES_SVH
`define FONT_PALETTE_GRADIENT_CORE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define FPG_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked while out of reset
`define FPG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/fpg_pkg.sv @@
package fpg_pkg;

   typedef struct packed {
      logic [3:0] palette_slot;
      logic [7:0] fore_byte0;
      logic [7:0] fore_byte1;
      logic [7:0] fore_byte2;
      logic [7:0] fore_alpha;
      logic [7:0] back_byte0;
      logic [7:0] back_byte1;
      logic [7:0] back_byte2;
      logic       game_mode;
   } req_type;

   typedef struct packed {
      logic [3:0]  slot_out;
      logic [3:0]  entry_index;
      logic [15:0] entry_value;
      logic        last_entry;
   } rsp_type;

   // per-entry control that rides along the pipeline
   typedef struct packed {
      logic [3:0] slot;
      logic [3:0] idx;
      logic       blend;
   } meta_type;

   localparam int         NumChan    = 3;
   localparam logic [3:0] LastIdx    = 4'hF;
   localparam logic [3:0] BlendFirst = 4'd4;
   localparam logic [3:0] HoldFirst  = 4'd8;
   localparam logic [3:0] PlainFirst = 4'd12;
   localparam logic [15:0] TransBit  = 16'h8000;
   localparam logic [15:0] ZeroSub   = 16'h0400;

   // reciprocal of 0xEF1: (x * BlendRecip) >> BlendShift is x / 0xEF1 for x up to 118575
   localparam logic [17:0] BlendRecip = 18'd140359;
   localparam int          BlendShift = 29;
   // reciprocal of 0xFF: (x * QuantRecip) >> QuantShift is x / 0xFF for x up to 7905
   localparam logic [13:0] QuantRecip = 14'd8225;
   localparam int          QuantShift = 21;

endpackage

@@ rtl/font_palette_gradient_core.sv @@
// channel  direction  handshake              word
// req      in         req_valid / req_ready  fpg_pkg::req_type, one palette request
// rsp      out        rsp_valid / rsp_ready  fpg_pkg::rsp_type, one table entry
//
// each request gives sixteen entries, one per cycle while rsp does not stall, so a new
// request is taken as the holder gives out its last entry; the entry counter in the holder tracks that
// the first entry passes the request holder, stages 1 to 3 and the output register before it shows on rsp
// reset is synchronous and active high; it drops all words in flight
// a stall on rsp freezes the whole pipeline; nothing is lost or repeated
module font_palette_gradient_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fpg_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fpg_pkg::rsp_type rsp_word
);
   import fpg_pkg::*;

   // request holder and entry counter
   req_type    hold_ff;
   logic       hold_valid_ff, hold_valid_in;
   logic [3:0] idx_ff, idx_in;

   // pipeline advance: everything moves unless the output word is stuck
   logic adv;
   logic issue;
   logic last_issue;
   logic accept;

   // stage 1: channel times weight
   logic [11:0] s1_fp_ff [NumChan];
   logic [11:0] s1_bp_ff [NumChan];
   logic [7:0]  s1_fc_ff [NumChan];
   logic [11:0] s1_fp_in [NumChan];
   logic [11:0] s1_bp_in [NumChan];
   logic [7:0]  s1_fc_in [NumChan];
   meta_type    s1_meta_ff, s1_meta_in;
   logic        s1_valid_ff;

   // stage 2: times 31
   logic [16:0] s2_fx_ff [NumChan];
   logic [16:0] s2_bx_ff [NumChan];
   logic [12:0] s2_qx_ff [NumChan];
   logic [16:0] s2_fx_in [NumChan];
   logic [16:0] s2_bx_in [NumChan];
   logic [12:0] s2_qx_in [NumChan];
   meta_type    s2_meta_ff;
   logic        s2_valid_ff;

   // stage 3: divide by the constants
   logic [34:0] f_prod [NumChan];
   logic [34:0] b_prod [NumChan];
   logic [26:0] q_prod [NumChan];
   logic [4:0] s3_fd_ff [NumChan];
   logic [4:0] s3_bd_ff [NumChan];
   logic [4:0] s3_qd_ff [NumChan];
   logic [4:0] s3_fd_in [NumChan];
   logic [4:0] s3_bd_in [NumChan];
   logic [4:0] s3_qd_in [NumChan];
   meta_type   s3_meta_ff;
   logic       s3_valid_ff;

   // output register
   rsp_type rsp_word_ff, rsp_word_in;
   logic    rsp_valid_ff;

   // stage 4 helpers
   logic [14:0] blend_rgb;
   logic [14:0] quant_rgb;
   logic [15:0] blend_val;
   logic [15:0] entry_val;

   assign adv        = !rsp_valid_ff || rsp_ready;
   assign issue      = hold_valid_ff && adv;
   assign last_issue = issue && (idx_ff == LastIdx);
   // a new request may land in the same cycle the last entry leaves the holder
   assign req_ready  = !hold_valid_ff || last_issue;
   assign accept     = req_valid && req_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      idx_in        = idx_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         idx_in        = '0;
      end else if (last_issue) begin
         hold_valid_in = 1'b0;
      end else if (issue) begin
         idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= req_word;
      end
   end

   // stage 1: weights are i for the foreground and 15 - i for the background
   always_comb begin
      s1_fc_in[0] = hold_ff.fore_byte0;
      s1_fc_in[1] = hold_ff.fore_byte1;
      s1_fc_in[2] = hold_ff.fore_byte2;
      s1_fp_in[0] = 12'(hold_ff.fore_byte0) * 12'(idx_ff);
      s1_fp_in[1] = 12'(hold_ff.fore_byte1) * 12'(idx_ff);
      s1_fp_in[2] = 12'(hold_ff.fore_byte2) * 12'(idx_ff);
      s1_bp_in[0] = 12'(hold_ff.back_byte0) * 12'(LastIdx - idx_ff);
      s1_bp_in[1] = 12'(hold_ff.back_byte1) * 12'(LastIdx - idx_ff);
      s1_bp_in[2] = 12'(hold_ff.back_byte2) * 12'(LastIdx - idx_ff);
      s1_meta_in.slot  = hold_ff.palette_slot;
      s1_meta_in.idx   = idx_ff;
      s1_meta_in.blend = !hold_ff.game_mode || (hold_ff.fore_alpha != 8'd0);
   end

   // stage 2: x * 31 as a shift and subtract
   always_comb begin
      for (int c = 0; c < NumChan; c++) begin
         s2_fx_in[c] = (17'(s1_fp_ff[c]) << 5) - 17'(s1_fp_ff[c]);
         s2_bx_in[c] = (17'(s1_bp_ff[c]) << 5) - 17'(s1_bp_ff[c]);
         s2_qx_in[c] = (13'(s1_fc_ff[c]) << 5) - 13'(s1_fc_ff[c]);
      end
   end

   // stage 3: reciprocal multiply, every quotient is known to be at most 31
   always_comb begin
      for (int c = 0; c < NumChan; c++) begin
         f_prod[c]   = 35'(s2_fx_ff[c]) * 35'(BlendRecip);
         b_prod[c]   = 35'(s2_bx_ff[c]) * 35'(BlendRecip);
         q_prod[c]   = 27'(s2_qx_ff[c]) * 27'(QuantRecip);
         s3_fd_in[c] = f_prod[c][BlendShift +: 5];
         s3_bd_in[c] = b_prod[c][BlendShift +: 5];
         s3_qd_in[c] = q_prod[c][QuantShift +: 5];
      end
   end

   // stage 4: add the two blend terms, pack, pick the mode
   always_comb begin
      // truncated sums never pass 31
      blend_rgb = {5'(s3_fd_ff[0] + s3_bd_ff[0]),
                   5'(s3_fd_ff[1] + s3_bd_ff[1]),
                   5'(s3_fd_ff[2] + s3_bd_ff[2])};
      quant_rgb = {s3_qd_ff[0], s3_qd_ff[1], s3_qd_ff[2]};
      blend_val = {(s3_meta_ff.slot == LastIdx), blend_rgb};
      entry_val = '0;
      if (s3_meta_ff.blend) begin
         if (s3_meta_ff.idx >= BlendFirst) begin
            entry_val = (blend_val == 16'd0) ? ZeroSub : blend_val;
         end
      end else if (s3_meta_ff.idx >= PlainFirst) begin
         entry_val = (quant_rgb == 15'd0) ? ZeroSub : {1'b0, quant_rgb};
      end else if (s3_meta_ff.idx >= HoldFirst) begin
         entry_val = TransBit | {1'b0, quant_rgb};
      end
      rsp_word_in.slot_out    = s3_meta_ff.slot;
      rsp_word_in.entry_index = s3_meta_ff.idx;
      rsp_word_in.entry_value = entry_val;
      rsp_word_in.last_entry  = (s3_meta_ff.idx == LastIdx);
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // payload stages, no reset
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_fp_ff    <= s1_fp_in;
         s1_bp_ff    <= s1_bp_in;
         s1_fc_ff    <= s1_fc_in;
         s1_meta_ff  <= s1_meta_in;
         s2_fx_ff    <= s2_fx_in;
         s2_bx_ff    <= s2_bx_in;
         s2_qx_ff    <= s2_qx_in;
         s2_meta_ff  <= s1_meta_ff;
         s3_fd_ff    <= s3_fd_in;
         s3_bd_ff    <= s3_bd_in;
         s3_qd_ff    <= s3_qd_in;
         s3_meta_ff  <= s2_meta_ff;
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ rtl/fpg_checker.sv @@
`include "font_palette_gradient_core_defines.svh"

module fpg_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fpg_pkg::rsp_type rsp_word
);
   import fpg_pkg::*;

   // a stalled word stays put
   `FPG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "rsp word changed while stalled")

   // the sixteen entries of one table stream without gaps
   `FPG_ASSERT_NEXT(a_run_gapless, rsp_valid && rsp_ready && !rsp_word.last_entry, rsp_valid && (rsp_word.slot_out == $past(rsp_word.slot_out)) && (rsp_word.entry_index == $past(rsp_word.entry_index) + 4'd1), "table run broken")

   // last flag marks entry fifteen only
   `FPG_ASSERT_SAME(a_last_flag, rsp_valid, rsp_word.last_entry == (rsp_word.entry_index == LastIdx), "last flag mismatch")

   // the first four entries are always transparent black
   `FPG_ASSERT_SAME(a_low_zero, rsp_valid && (rsp_word.entry_index < BlendFirst), rsp_word.entry_value == 16'd0, "low entry not zero")

endmodule

bind font_palette_gradient_core fpg_checker u_fpg_checker (.*);
